@@ design/lpht_pkg.sv @@
// Package for the linear-probe hash table unit: sizes, codes, state and link types.
// It depends on nothing and is imported by every module of the unit.
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int unsigned INDEX_BITS  = 8;
  localparam int unsigned KEY_BITS    = 64;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned DEPTH       = 1 << INDEX_BITS;
  localparam int unsigned COUNT_BITS  = 9;
  localparam int unsigned LIMIT_BITS  = 8;
  localparam int unsigned SLOT_BITS   = 8;
  localparam int unsigned STATUS_BITS = 3;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(128);

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LIMIT_BITS-1:0] limit_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_FOUND     = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_INSERTED  = 3'd2,
    STATUS_UPDATED   = 3'd3,
    STATUS_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_RESP
  } state_e;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_INSERT = 1'b1
  } command_e;

  typedef struct packed {
    logic   wr_key;
    logic   wr_value;
    index_t addr;
  } store_wr_t;

  typedef struct packed {
    logic    hit;
    value_t  read_value;
    status_e status;
    index_t  slot;
  } resp_t;

endpackage

@@ design/lpht_store.sv @@
// Slot store of the hash table: key and value memories with registered reads,
// and the per-slot valid flags. Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpht_pkg::index_t   rd_addr_i,
  input  lpht_pkg::index_t   probe_addr_i,
  input  lpht_pkg::store_wr_t wr_i,
  input  lpht_pkg::key_t     wr_key_i,
  input  lpht_pkg::value_t   wr_value_i,
  output lpht_pkg::key_t     rd_key_o,
  output lpht_pkg::value_t   rd_value_o,
  output logic               slot_valid_o
);
  import lpht_pkg::*;

  key_t             key_mem_q   [DEPTH];
  value_t           value_mem_q [DEPTH];
  key_t             rd_key_q;
  value_t           rd_value_q;
  logic [DEPTH-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_key) begin
      key_mem_q[wr_i.addr] <= wr_key_i;
    end
    rd_key_q <= key_mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_value) begin
      value_mem_q[wr_i.addr] <= wr_value_i;
    end
    rd_value_q <= value_mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.wr_key) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  assign rd_key_o     = rd_key_q;
  assign rd_value_o   = rd_value_q;
  assign slot_valid_o = valid_q[probe_addr_i];

endmodule

@@ design/lpht_ctrl.sv @@
// Probe sequencer: walks the slots one per cycle with a single key comparator,
// keeps the entry count and load limit, and issues store writes. Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  lpht_pkg::key_t      key_i,
  input  lpht_pkg::value_t    value_i,
  input  logic                cfg_we_i,
  input  lpht_pkg::limit_t    cfg_wdata_i,
  output lpht_pkg::index_t    rd_addr_o,
  output lpht_pkg::index_t    probe_addr_o,
  input  logic                slot_valid_i,
  input  lpht_pkg::key_t      rd_key_i,
  input  lpht_pkg::value_t    rd_value_i,
  output lpht_pkg::store_wr_t wr_o,
  output lpht_pkg::key_t      wr_key_o,
  output lpht_pkg::value_t    wr_value_o,
  output logic                resp_valid_o,
  input  logic                resp_ready_i,
  output lpht_pkg::resp_t     resp_o
);
  import lpht_pkg::*;

  state_e   state_q, state_d;
  command_e cmd_q, cmd_d;
  key_t     key_q, key_d;
  value_t   value_q, value_d;
  index_t   pos_q, pos_d;
  index_t   steps_q, steps_d;
  limit_t   limit_q;
  count_t   count_q, count_d;
  resp_t    res_q, res_d;

  logic match, empty, last_step, room;

  assign match     = slot_valid_i && (rd_key_i == key_q);
  assign empty     = !slot_valid_i;
  assign last_step = (steps_q == '1);
  assign room      = (count_q < COUNT_BITS'(limit_q));

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    value_d      = value_q;
    pos_d        = pos_q;
    steps_d      = steps_q;
    count_d      = count_q;
    res_d        = res_q;
    in_ready_o   = 1'b0;
    resp_valid_o = 1'b0;
    rd_addr_o    = pos_q + index_t'(1);
    wr_o         = '{wr_key: 1'b0, wr_value: 1'b0, addr: res_q.slot};

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr_o  = key_i[INDEX_BITS-1:0];
        if (in_valid_i) begin
          cmd_d   = command_e'(command_i);
          key_d   = key_i;
          value_d = value_i;
          pos_d   = key_i[INDEX_BITS-1:0];
          steps_d = '0;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (match || empty || last_step) begin
          res_d.hit        = match;
          res_d.slot       = (match || empty) ? pos_q : key_q[INDEX_BITS-1:0];
          res_d.read_value = (cmd_q == CMD_LOOKUP && match) ? rd_value_i : '0;
          if (cmd_q == CMD_LOOKUP) begin
            res_d.status = match ? STATUS_FOUND : STATUS_NOT_FOUND;
          end else if (match) begin
            res_d.status = STATUS_UPDATED;
          end else if (empty && room) begin
            res_d.status = STATUS_INSERTED;
          end else begin
            res_d.status = STATUS_FULL;
          end
          state_d = ST_RESP;
        end else begin
          pos_d   = pos_q + index_t'(1);
          steps_d = steps_q + index_t'(1);
        end
      end
      ST_RESP: begin
        resp_valid_o = 1'b1;
        if (resp_ready_i) begin
          wr_o.wr_key   = (res_q.status == STATUS_INSERTED);
          wr_o.wr_value = (res_q.status == STATUS_INSERTED)
                       || (res_q.status == STATUS_UPDATED);
          if (res_q.status == STATUS_INSERTED) begin
            count_d = count_q + count_t'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    value_q <= value_d;
    pos_q   <= pos_d;
    steps_q <= steps_d;
    res_q   <= res_d;
  end

  assign probe_addr_o = pos_q;
  assign wr_key_o     = key_q;
  assign wr_value_o   = value_q;
  assign resp_o       = res_q;

endmodule

@@ design/linear_probe_hash_table_unit.sv @@
// Top level of the linear-probe hash table unit: sequencer, slot store and the
// result register. Depends on lpht_pkg, lpht_store and lpht_ctrl.
//
//   Channel   Direction  Handshake                  Payload
//   in        request    in_valid_i / in_ready_o    command_i, key_i, value_i
//   out       result     out_valid_o / out_ready_i  hit_o, read_value_o, status_o, slot_o
//   cfg       write      cfg_we_i                   cfg_wdata_i (load limit)
//
// Each request probes k of the slots, where k runs from 1 to 256;
// the single key comparator checks one slot per cycle from the registered memory read.
// Reset clears the valid flags, the entry count and sets the load limit to 128.
// The result register lets a new request be accepted while a result waits; the
// sequencer holds its result only if that register is still occupied.
`timescale 1ns / 1ps

module linear_probe_hash_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  lpht_pkg::key_t                key_i,
  input  lpht_pkg::value_t              value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output lpht_pkg::value_t              read_value_o,
  output logic [lpht_pkg::STATUS_BITS-1:0] status_o,
  output logic [lpht_pkg::SLOT_BITS-1:0]   slot_o,
  input  logic                          cfg_we_i,
  input  lpht_pkg::limit_t              cfg_wdata_i
);
  import lpht_pkg::*;

  index_t    rd_addr, probe_addr;
  logic      slot_valid;
  key_t      rd_key, wr_key;
  value_t    rd_value, wr_value;
  store_wr_t wr;
  logic      resp_valid, resp_ready;
  resp_t     resp;

  logic   out_valid_q;
  resp_t  out_q;

  lpht_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rd_addr_o    (rd_addr),
    .probe_addr_o (probe_addr),
    .slot_valid_i (slot_valid),
    .rd_key_i     (rd_key),
    .rd_value_i   (rd_value),
    .wr_o         (wr),
    .wr_key_o     (wr_key),
    .wr_value_o   (wr_value),
    .resp_valid_o (resp_valid),
    .resp_ready_i (resp_ready),
    .resp_o       (resp)
  );

  lpht_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_addr_i    (rd_addr),
    .probe_addr_i (probe_addr),
    .wr_i         (wr),
    .wr_key_i     (wr_key),
    .wr_value_i   (wr_value),
    .rd_key_o     (rd_key),
    .rd_value_o   (rd_value),
    .slot_valid_o (slot_valid)
  );

  assign resp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_ready) begin
      out_valid_q <= resp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_ready && resp_valid) begin
      out_q <= resp;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_q.hit;
  assign read_value_o = out_q.read_value;
  assign status_o     = out_q.status;
  assign slot_o       = SLOT_BITS'(out_q.slot);

endmodule

@@ sim/linear_probe_hash_table_unit_tb.sv @@
// Self-checking testbench for the linear-probe hash table unit: directed and random
// lookups and inserts against a table model, with random stalls on both channels.
// Depends on lpht_pkg and linear_probe_hash_table_unit.
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_tb;
  import lpht_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       command_i   = 1'b0;
  key_t       key_i       = '0;
  value_t     value_i     = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       hit_o;
  value_t     read_value_o;
  logic [STATUS_BITS-1:0] status_o;
  logic [SLOT_BITS-1:0]   slot_o;
  logic       cfg_we_i    = 1'b0;
  limit_t     cfg_wdata_i = '0;

  key_t   tbl_keys  [DEPTH];
  value_t tbl_vals  [DEPTH];
  bit     tbl_valid [DEPTH];
  count_t entry_total;
  limit_t load_limit;

  resp_t pending_results[$];
  int    mismatch_count = 0;
  int    stall_left     = 0;
  bit    quiet_phase    = 1'b0;

  linear_probe_hash_table_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hit_o        (hit_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic resp_t probe_and_update(command_e cmd, key_t key, value_t val);
    resp_t  r;
    index_t home;
    index_t pos;
    bit     matched;
    bit     empty;
    int     n;
    home    = key[INDEX_BITS-1:0];
    pos     = home;
    matched = 1'b0;
    empty   = 1'b0;
    n       = 0;
    while (n < DEPTH && !matched && !empty) begin
      if (!tbl_valid[pos]) begin
        empty = 1'b1;
      end else if (tbl_keys[pos] == key) begin
        matched = 1'b1;
      end else begin
        pos = pos + 1'b1;
        n++;
      end
    end
    r.hit        = matched;
    r.read_value = '0;
    r.slot       = pos;
    if (cmd == CMD_LOOKUP) begin
      if (matched) begin
        r.read_value = tbl_vals[pos];
        r.status     = STATUS_FOUND;
      end else begin
        r.status = STATUS_NOT_FOUND;
      end
    end else if (matched) begin
      tbl_vals[pos] = val;
      r.status      = STATUS_UPDATED;
    end else if (!empty || entry_total >= load_limit) begin
      r.status = STATUS_FULL;
    end else begin
      tbl_keys[pos]  = key;
      tbl_vals[pos]  = val;
      tbl_valid[pos] = 1'b1;
      entry_total    = entry_total + 1'b1;
      r.status       = STATUS_INSERTED;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    resp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, status %0d slot %0d",
                                    status_o, slot_o));
        end else begin
          want = pending_results.pop_front();
          if (hit_o !== want.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", hit_o, want.hit));
          if (read_value_o !== want.read_value)
            report_mismatch($sformatf("read_value %0h, expected %0h", read_value_o,
                                      want.read_value));
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
          if (slot_o !== want.slot)
            report_mismatch($sformatf("slot %0d, expected %0d", slot_o, want.slot));
        end
      end
      if (quiet_phase) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(command_e cmd, key_t key, value_t val);
    int gap;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= key;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(probe_and_update(cmd, key, val));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(limit_t limit);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    load_limit = limit;
  endtask

  function automatic key_t pick_key();
    key_t   k;
    index_t idx;
    int     sel;
    sel = $urandom_range(0, 3);
    idx = index_t'($urandom);
    k   = {$urandom, $urandom};
    if (sel < 2 && entry_total != 0) begin
      while (!tbl_valid[idx]) idx = idx + 1'b1;
      k = tbl_keys[idx];
    end else if (sel == 2) begin
      k[INDEX_BITS-1:0] = index_t'($urandom_range(248, 255));
    end
    return k;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_request(command_e'($urandom_range(0, 1)), pick_key(), $urandom);
  endtask

  task automatic test_basic_operations();
    send_request(CMD_LOOKUP, 64'h0, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, '1, 32'h0);
    send_request(CMD_INSERT, 64'h0, 32'h0);
    send_request(CMD_INSERT, '1, '1);
    send_request(CMD_LOOKUP, '1, 32'h0);
    send_request(CMD_LOOKUP, 64'h0, 32'h0);
    send_request(CMD_INSERT, 64'h100, 32'hA5A5_5A5A);
    send_request(CMD_INSERT, 64'h8000_0000_0000_00FF, 32'h5A5A_A5A5);
    send_request(CMD_LOOKUP, 64'h8000_0000_0000_00FF, 32'h0);
    send_request(CMD_INSERT, 64'h0, 32'h1234_5678);
    send_request(CMD_LOOKUP, 64'h0, 32'h0);
    send_request(CMD_LOOKUP, 64'h200, 32'h0);
    send_request(CMD_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001);
    send_request(CMD_LOOKUP, 64'h8000_0000_0000_0000, 32'h0);
    send_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF7F, 32'h0);
    send_request(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FF7F, 32'h0);
  endtask

  task automatic test_zero_limit();
    write_limit(limit_t'(0));
    send_request(CMD_INSERT, {$urandom, $urandom}, $urandom);
    send_request(CMD_INSERT, 64'h0, $urandom);
    send_request(CMD_LOOKUP, 64'h0, $urandom);
  endtask

  task automatic test_count_limit();
    write_limit(limit_t'(entry_total + 2));
    repeat (3) send_request(CMD_INSERT, {$urandom, $urandom}, $urandom);
  endtask

  task automatic test_random_moderate_load();
    write_limit(limit_t'(60));
    run_random(90);
    wait_idle();
    run_random(90);
  endtask

  task automatic test_fill_to_max();
    write_limit(limit_t'(255));
    run_random(150);
    while (entry_total < 255) send_request(CMD_INSERT, {$urandom, $urandom}, $urandom);
  endtask

  task automatic test_longest_probe();
    index_t hole;
    key_t   k;
    hole = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!tbl_valid[index_t'(i)]) hole = index_t'(i);
    end
    k = {$urandom, $urandom};
    k[INDEX_BITS-1:0] = hole + 1'b1;
    send_request(CMD_LOOKUP, k, $urandom);
    send_request(CMD_INSERT, k, $urandom);
    k[INDEX_BITS-1:0] = hole;
    send_request(CMD_LOOKUP, k, $urandom);
    send_request(CMD_INSERT, tbl_keys[index_t'(hole + 1'b1)], $urandom);
  endtask

  task automatic test_min_limit_no_idle();
    write_limit(limit_t'(1));
    quiet_phase = 1'b1;
    run_random(100);
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) tbl_valid[index_t'(i)] = 1'b0;
    entry_total = '0;
    load_limit  = LIMIT_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_operations();
    test_zero_limit();
    test_count_limit();
    test_random_moderate_load();
    test_fill_to_max();
    test_longest_probe();
    test_min_limit_no_idle();
    wait_idle();
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lpht_pkg.sv
design/lpht_store.sv
design/lpht_ctrl.sv
design/linear_probe_hash_table_unit.sv
sim/linear_probe_hash_table_unit_tb.sv
